[design/rau_pkg.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, command codes, payload structs and controller interface.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int CNT_WIDTH  = $clog2(DATA_WIDTH + 1);

   typedef enum logic [2:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_EQ  = 3'd4
   } cmd_type;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] left_num;
      logic signed [31:0] left_den;
      logic signed [31:0] right_num;
      logic signed [31:0] right_den;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_num;
      logic signed [31:0] result_den;
      logic               is_equal;
      logic               overflowed;
   } rsp_type;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,     // capture operands
      OP_MUL,      // one multiply into product slot
      OP_ADDSUB,   // combine cross products into numerator
      OP_FINISH,   // place result parts or equality flag
      OP_GCD_TZ,   // strip common factors of two
      OP_GCD_A,    // make a odd
      OP_GCD_STEP, // one subtract step
      OP_DIV_INIT, // prepare division by gcd
      OP_DIV_STEP, // one restoring division bit
      OP_DIV_DONE  // store quotient
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] sel;   // multiply slot or division target
   } dp_cmd_type;

   typedef struct packed {
      logic gcd_tz_done;
      logic gcd_a_odd;
      logic gcd_done;
      logic div_last;
      logic skip_gcd;
   } dp_sts_type;

endpackage

[design/rau_datapath.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit datapath
// Operand registers, one shared multiplier, binary gcd and restoring divider.
// ----------------------------------------------------------------------------
module rau_datapath (
   input  logic                clock,
   input  logic                reset,
   input  rau_pkg::req_type    req,
   input  rau_pkg::dp_cmd_type cmd,
   output rau_pkg::dp_sts_type sts,
   output rau_pkg::rsp_type    result
);
   import rau_pkg::*;

   localparam int W = DATA_WIDTH;

   logic [2:0]   cmd_ff;
   logic [W-1:0] ln_ff, ld_ff, rn_ff, rd_ff;
   logic [W-1:0] p_ff [3];
   logic [W-1:0] num_ff, den_ff;
   logic         ov_ff, eq_ff;
   logic [W-1:0] ga_ff, gb_ff;
   logic [CNT_WIDTH-1:0] k_ff;
   logic [W-1:0] g_ff;
   logic [W-1:0] dq_ff;
   logic [W:0]   dr_ff;
   logic [CNT_WIDTH-1:0] dc_ff;

   function automatic logic [W-1:0] from_field(logic [31:0] v);
      logic [63:0] e;
      e = {{32{v[31]}}, v};
      return e[W-1:0];
   endfunction

   function automatic logic [31:0] to_field(logic [W-1:0] v);
      logic [63:0] e;
      e = {{(64-W){v[W-1]}}, v};
      return e[31:0];
   endfunction

   function automatic logic [W-1:0] mag(logic [W-1:0] v);
      return v[W-1] ? (~v + 1'b1) : v;
   endfunction

   // Operand selection for the multiplier.
   logic [W-1:0] ma, mb;
   always_comb begin
      ma = ln_ff;
      mb = rd_ff;
      case (cmd.sel)
         2'd0: begin
            ma = ln_ff;
            mb = (cmd_ff == CMD_MUL) ? rn_ff : rd_ff;
         end
         2'd1: begin
            ma = (cmd_ff == CMD_ADD || cmd_ff == CMD_SUB || cmd_ff == CMD_EQ) ? rn_ff : ld_ff;
            mb = (cmd_ff == CMD_ADD || cmd_ff == CMD_SUB || cmd_ff == CMD_EQ) ? ld_ff
               : ((cmd_ff == CMD_MUL) ? rd_ff : rn_ff);
         end
         default: begin
            ma = ld_ff;
            mb = rd_ff;
         end
      endcase
   end

   logic [2*W-1:0] prod_mag;
   logic           prod_neg, mul_ov;
   logic [W-1:0]   prod_w;
   always_comb begin
      prod_mag = mag(ma) * mag(mb);
      prod_neg = (ma[W-1] ^ mb[W-1]) && (prod_mag != '0);
      if (prod_neg)
         mul_ov = prod_mag > {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};
      else
         mul_ov = prod_mag > {{(W+1){1'b0}}, {(W-1){1'b1}}};
      prod_w = prod_neg ? (~prod_mag[W-1:0] + 1'b1) : prod_mag[W-1:0];
   end

   logic [W-1:0] as_r;
   logic         as_sub, as_ov;
   always_comb begin
      as_sub = (cmd_ff == CMD_SUB);
      as_r   = as_sub ? (p_ff[0] - p_ff[1]) : (p_ff[0] + p_ff[1]);
      if (as_sub)
         as_ov = (p_ff[0][W-1] != p_ff[1][W-1]) && (as_r[W-1] != p_ff[0][W-1]);
      else
         as_ov = (p_ff[0][W-1] == p_ff[1][W-1]) && (as_r[W-1] != p_ff[0][W-1]);
   end

   logic [W-1:0] mn, md;
   assign mn = mag(num_ff);
   assign md = mag(den_ff);

   logic [W-1:0] gb_odd_next, gb_sub_a, gb_sub_b;
   always_comb begin
      gb_sub_a = ga_ff;
      gb_sub_b = gb_ff;
      if (!gb_ff[0]) begin
         gb_odd_next = gb_ff >> 1;
      end else begin
         if (ga_ff > gb_ff) begin
            gb_sub_a = gb_ff;
            gb_sub_b = ga_ff;
         end
         gb_odd_next = gb_sub_b - gb_sub_a;
      end
   end

   logic [W:0] dr_shift, dr_trial;
   assign dr_shift = {dr_ff[W-1:0], dq_ff[W-1]};
   assign dr_trial = dr_shift - {1'b0, g_ff};

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            cmd_ff <= req.command;
            ln_ff  <= from_field(req.left_num);
            ld_ff  <= from_field(req.left_den);
            rn_ff  <= from_field(req.right_num);
            rd_ff  <= from_field(req.right_den);
            ov_ff  <= 1'b0;
            eq_ff  <= 1'b0;
            num_ff <= '0;
            den_ff <= {{(W-1){1'b0}}, 1'b1};
         end
         OP_MUL: begin
            p_ff[cmd.sel] <= prod_w;
            if (mul_ov)
               ov_ff <= 1'b1;
         end
         OP_ADDSUB: begin
            num_ff <= as_r;
            if (as_ov)
               ov_ff <= 1'b1;
         end
         OP_FINISH: begin
            case (cmd_ff)
               CMD_ADD, CMD_SUB: den_ff <= p_ff[2];
               CMD_MUL, CMD_DIV: begin
                  num_ff <= p_ff[0];
                  den_ff <= p_ff[1];
               end
               CMD_EQ: eq_ff <= (p_ff[0] == p_ff[1]);
               default: ;
            endcase
         end
         OP_GCD_TZ: begin
            if (ga_ff[0] | gb_ff[0]) begin
            end else begin
               ga_ff <= ga_ff >> 1;
               gb_ff <= gb_ff >> 1;
               k_ff  <= k_ff + 1'b1;
            end
         end
         OP_GCD_A: begin
            if (!ga_ff[0])
               ga_ff <= ga_ff >> 1;
         end
         OP_GCD_STEP: begin
            if (gb_ff[0])
               ga_ff <= gb_sub_a;
            gb_ff <= gb_odd_next;
         end
         OP_DIV_INIT: begin
            dq_ff <= (cmd.sel == 2'd0) ? mn : md;
            dr_ff <= '0;
            dc_ff <= '0;
            if (cmd.sel == 2'd0)
               g_ff <= ga_ff << k_ff;
         end
         OP_DIV_STEP: begin
            dc_ff <= dc_ff + 1'b1;
            if (!dr_trial[W]) begin
               dr_ff <= dr_trial;
               dq_ff <= {dq_ff[W-2:0], 1'b1};
            end else begin
               dr_ff <= dr_shift;
               dq_ff <= {dq_ff[W-2:0], 1'b0};
            end
         end
         OP_DIV_DONE: begin
            if (cmd.sel == 2'd0)
               num_ff <= num_ff[W-1] ? (~dq_ff + 1'b1) : dq_ff;
            else
               den_ff <= den_ff[W-1] ? (~dq_ff + 1'b1) : dq_ff;
         end
         default: ;
      endcase
      // Gcd operands are loaded by the division setup with target two, after the finish step.
      if (cmd.op == OP_DIV_INIT && cmd.sel == 2'd2) begin
         ga_ff <= mn;
         gb_ff <= md;
         k_ff  <= '0;
      end
      if (reset) begin
         cmd_ff <= CMD_EQ;
      end
   end

   always_comb begin
      sts.gcd_tz_done = ga_ff[0] | gb_ff[0];
      sts.gcd_a_odd   = ga_ff[0];
      sts.gcd_done    = (gb_ff == '0);
      sts.div_last    = (dc_ff == CNT_WIDTH'(W - 1));
      sts.skip_gcd    = (cmd_ff > 3'(CMD_DIV)) || (mn == '0) || (md == '0);
   end

   always_comb begin
      result.result_num = to_field(num_ff);
      result.result_den = to_field(den_ff);
      result.is_equal   = eq_ff;
      result.overflowed = ov_ff;
   end

endmodule

[design/rau_control.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit controller
// Sequences multiplies, gcd reduction and the two divisions of one item.
// ----------------------------------------------------------------------------
module rau_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [2:0]          req_command,
   output rau_pkg::dp_cmd_type cmd,
   input  rau_pkg::dp_sts_type sts
);
   import rau_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b000000000001,
      ST_MUL    = 12'b000000000010,
      ST_ADDSUB = 12'b000000000100,
      ST_FINISH = 12'b000000001000,
      ST_GSETUP = 12'b000000010000,
      ST_GTZ    = 12'b000000100000,
      ST_GA     = 12'b000001000000,
      ST_GSTEP  = 12'b000010000000,
      ST_DINIT  = 12'b000100000000,
      ST_DSTEP  = 12'b001000000000,
      ST_DDONE  = 12'b010000000000,
      ST_OUT    = 12'b100000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] slot_ff, slot_in;
   logic [1:0] nmul_ff, nmul_in;
   logic       target_ff, target_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      state_in  = state_ff;
      slot_in   = slot_ff;
      nmul_in   = nmul_ff;
      target_in = target_ff;
      cmd.op    = OP_NONE;
      cmd.sel   = slot_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               slot_in  = 2'd0;
               nmul_in  = (req_command == CMD_ADD || req_command == CMD_SUB) ? 2'd3 : 2'd2;
               state_in = (req_command > 3'(CMD_EQ)) ? ST_OUT : ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.op  = OP_MUL;
            slot_in = slot_ff + 1'b1;
            if (slot_ff == nmul_ff - 1'b1)
               state_in = (nmul_ff == 2'd3) ? ST_ADDSUB : ST_FINISH;
         end
         ST_ADDSUB: begin
            cmd.op   = OP_ADDSUB;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.op   = OP_FINISH;
            state_in = ST_GSETUP;
         end
         ST_GSETUP: begin
            if (sts.skip_gcd) begin
               state_in = ST_OUT;
            end else begin
               cmd.op   = OP_DIV_INIT;
               cmd.sel  = 2'd2;
               state_in = ST_GTZ;
            end
         end
         ST_GTZ: begin
            cmd.op = OP_GCD_TZ;
            if (sts.gcd_tz_done)
               state_in = ST_GA;
         end
         ST_GA: begin
            cmd.op = OP_GCD_A;
            if (sts.gcd_a_odd)
               state_in = ST_GSTEP;
         end
         ST_GSTEP: begin
            cmd.op = OP_GCD_STEP;
            if (sts.gcd_done) begin
               cmd.op    = OP_NONE;
               target_in = 1'b0;
               state_in  = ST_DINIT;
            end
         end
         ST_DINIT: begin
            cmd.op   = OP_DIV_INIT;
            cmd.sel  = {1'b0, target_ff};
            state_in = ST_DSTEP;
         end
         ST_DSTEP: begin
            cmd.op  = OP_DIV_STEP;
            cmd.sel = {1'b0, target_ff};
            if (sts.div_last)
               state_in = ST_DDONE;
         end
         ST_DDONE: begin
            // The quotient is written back with the sign of its part.
            cmd.op  = OP_DIV_DONE;
            cmd.sel = {1'b0, target_ff};
            if (target_ff) begin
               state_in = ST_OUT;
            end else begin
               target_in = 1'b1;
               state_in  = ST_DINIT;
            end
         end
         ST_OUT: begin
            if (rsp_ready)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      slot_ff   <= slot_in;
      nmul_ff   <= nmul_in;
      target_ff <= target_in;
   end

endmodule

[design/rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies, divides or compares two fractions and reduces
// the result by the gcd of its parts.
// ----------------------------------------------------------------------------
// The request channel carries one beat per item: a command and two fractions.
// The response channel returns one beat per item with the reduced fraction,
// an equality flag and an overflow flag. Items are handled one at a time:
// req_ready is high only while the unit is idle, so the next request is taken
// the cycle after the response beat has been accepted.
// Each item runs two or three multiplications on the shared 32x32 multiplier,
// then a binary gcd reduction of one shift or subtract step at a time, then
// two restoring divisions of the parts by the gcd. Compare, unused commands
// and results with a zero part skip the gcd and the divisions.
// A synchronous reset returns the unit to idle; any item in flight is lost.
// When the receiver stalls, the result holds on the response port and no new
// request is taken until it has been accepted.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rau_pkg::rsp_type rsp_data
);
   import rau_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   rau_control u_control (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .req_command (req_data.command),
      .cmd         (cmd),
      .sts         (sts)
   );

   rau_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req    (req_data),
      .cmd    (cmd),
      .sts    (sts),
      .result (rsp_data)
   );

endmodule

[tb/sv/tb_rational_arithmetic_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives command beats through the request channel with random gaps, predicts
// each reduced fraction and its flags, and checks every response beat in
// order, including a long receiver hold-off that backs up the request side.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit;
   import rau_pkg::*;

   localparam int RANDOM_ITEMS = 500;
   localparam int CYCLE_LIMIT  = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type fraction_queue[$];
   int      error_count = 0;
   int      cycle_count = 0;
   int      hold_off = 0;
   int      rsp_wait = 0;
   bit      sending_done = 1'b0;

   typedef struct {
      req_type stim;
      bit      known;
      rsp_type answer;
   } stim_row_type;

   stim_row_type stim_table[$];

   rational_arithmetic_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Wrapped 32-bit product; flags when the exact product does not fit.
   function automatic logic [31:0] wrap_mul(input logic [31:0] a, input logic [31:0] b,
                                            inout bit ov);
      logic signed [63:0] full;
      full = $signed(a) * $signed(b);
      if (full != {{32{full[31]}}, full[31:0]}) ov = 1'b1;
      return full[31:0];
   endfunction

   function automatic logic [31:0] magnitude(input logic [31:0] v);
      return v[31] ? -v : v;
   endfunction

   function automatic logic [31:0] common_divisor(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic rsp_type reduce_fraction(input req_type r);
      rsp_type     res;
      logic [31:0] num, den, p, q, s, g;
      bit          ov;
      ov = 1'b0;
      num = 32'd0;
      den = 32'd1;
      res = '0;
      case (r.command)
         CMD_ADD, CMD_SUB: begin
            p = wrap_mul(r.left_num, r.right_den, ov);
            q = wrap_mul(r.right_num, r.left_den, ov);
            s = (r.command == CMD_SUB) ? p - q : p + q;
            if (r.command == CMD_SUB ? (p[31] != q[31] && s[31] != p[31])
                                     : (p[31] == q[31] && s[31] != p[31])) ov = 1'b1;
            num = s;
            den = wrap_mul(r.left_den, r.right_den, ov);
         end
         CMD_MUL: begin
            num = wrap_mul(r.left_num, r.right_num, ov);
            den = wrap_mul(r.left_den, r.right_den, ov);
         end
         CMD_DIV: begin
            num = wrap_mul(r.left_num, r.right_den, ov);
            den = wrap_mul(r.left_den, r.right_num, ov);
         end
         CMD_EQ: begin
            p = wrap_mul(r.left_num, r.right_den, ov);
            q = wrap_mul(r.right_num, r.left_den, ov);
            res.is_equal = (p == q);
         end
         default: ;
      endcase
      if (r.command <= CMD_DIV && num != 0 && den != 0) begin
         g = common_divisor(magnitude(num), magnitude(den));
         num = num[31] ? -(magnitude(num) / g) : num / g;
         den = den[31] ? -(magnitude(den) / g) : den / g;
      end
      res.result_num = num;
      res.result_den = den;
      res.overflowed = ov;
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] seen,
                                  input logic [31:0] wanted);
      $display("Mismatch on %s: got %0h, expected %0h", field, seen, wanted);
      error_count++;
   endtask

   task automatic add_row(input logic [2:0] c, input int ln, input int ld, input int rn,
                          input int rd, input bit known = 0, input int an = 0,
                          input int ad = 1, input bit eq = 0, input bit ov = 0);
      stim_row_type row;
      row.stim = '{command: c, left_num: ln, left_den: ld, right_num: rn, right_den: rd};
      row.known = known;
      row.answer = '{result_num: an, result_den: ad, is_equal: eq, overflowed: ov};
      stim_table.push_back(row);
   endtask

   function automatic logic [31:0] random_operand();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 2) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
         2: return 32'd0;
         default: return $urandom_range(0, 1) ? $urandom_range(1, 2000)
                                              : -$urandom_range(1, 2000);
      endcase
   endfunction

   // Valid drops only when a gap follows, so back-to-back beats keep it high.
   task automatic send_beat(input req_type beat);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      fraction_queue.push_back(reduce_fraction(beat));
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      req_type beat;
      add_row(CMD_ADD, 1, 2, 1, 3, 1, 5, 6);
      add_row(CMD_SUB, 1, 2, 1, 2, 1, 0, 4);
      add_row(CMD_MUL, 2, 3, 3, 4, 1, 1, 2);
      add_row(CMD_DIV, 1, 2, 0, 1, 1, 1, 0);
      add_row(CMD_EQ, 1, 2, 2, 4, 1, 0, 1, 1, 0);
      add_row(CMD_EQ, 1, 2, 1, 3, 1, 0, 1, 0, 0);
      add_row(3'd5, 7, 7, 7, 7, 1, 0, 1);
      add_row(3'd7, -1, -1, -1, -1, 1, 0, 1);
      add_row(CMD_MUL, 32'h7fffffff, 1, 2, 1);
      add_row(CMD_ADD, 32'h80000000, 1, 32'h80000000, 1);
      add_row(CMD_SUB, 32'h80000000, 1, 1, 1);
      add_row(CMD_MUL, 32'h80000000, 1, -1, 1);
      add_row(CMD_DIV, -6, 4, 3, -8);
      add_row(CMD_MUL, 0, 5, 3, 0, 1, 0, 0);
      add_row(CMD_ADD, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      add_row(CMD_EQ, 32'h80000000, 2, 32'h80000000, 2);
      add_row(CMD_DIV, -1, -1, -1, -1);
      add_row(CMD_MUL, 32'h80000000, 32'h80000000, 1, 1);
      add_row(3'd6, 0, 0, 0, 0, 1, 0, 1);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (stim_table[i]) begin
         send_beat(stim_table[i].stim);
         if (stim_table[i].known) fraction_queue[$] = stim_table[i].answer;
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         beat.command   = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                       : 3'($urandom_range(0, 4));
         beat.left_num  = random_operand();
         beat.left_den  = random_operand();
         beat.right_num = random_operand();
         beat.right_den = random_operand();
         if (n == 100) hold_off = 600;
         send_beat(beat);
      end
      req_valid <= 1'b0;
      sending_done = 1'b1;
   end

   // Receiver: a random wait per beat plus one long hold-off to back up the
   // request side.
   always @(posedge clock) begin
      bit taken;
      taken = !reset && rsp_valid && rsp_ready;
      if (taken) begin
         rsp_wait = $urandom_range(0, 5);
         if (fraction_queue.size() == 0) begin
            $display("Unexpected response beat");
            error_count++;
         end else begin
            rsp_type want;
            want = fraction_queue.pop_front();
            if (rsp_data.result_num !== want.result_num)
               report_mismatch("result_num", rsp_data.result_num, want.result_num);
            if (rsp_data.result_den !== want.result_den)
               report_mismatch("result_den", rsp_data.result_den, want.result_den);
            if (rsp_data.is_equal !== want.is_equal)
               report_mismatch("is_equal", 32'(rsp_data.is_equal), 32'(want.is_equal));
            if (rsp_data.overflowed !== want.overflowed)
               report_mismatch("overflowed", 32'(rsp_data.overflowed),
                               32'(want.overflowed));
         end
      end
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_wait = rsp_wait - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      wait (sending_done);
      while (fraction_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0 && fraction_queue.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
